// File: rtl/core/apcs_pkg.sv
`default_nettype none

package apcs_pkg;

   // Table size and the index width that follows from it.
   localparam int SLOTS = 8;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // Collider kinds and the notify mask built from the three registers.
   localparam int KINDS     = 12;
   localparam int MASK_W    = 48;
   localparam int MASK_BITS = 3 * MASK_W;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_MID  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_HIGH = 2'd2;

   // Action codes on the request channel.
   localparam logic [2:0] ACT_ADD       = 3'd0;
   localparam logic [2:0] ACT_REMOVE    = 3'd1;
   localparam logic [2:0] ACT_CLEAR_ALL = 3'd2;
   localparam logic [2:0] ACT_CLEAR_MAP = 3'd3;
   localparam logic [2:0] ACT_SCAN      = 3'd4;

   // Status codes on the response channel.
   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_PAIR = 2'd2;
   localparam logic [1:0] STATUS_NONE = 2'd3;

   // Depth of the command queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // Classified operation handed from the front to the back.
   typedef enum logic [2:0] {
      OP_ADD,
      OP_REMOVE,
      OP_CLEAR_ALL,
      OP_CLEAR_MAP,
      OP_SCAN,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [IDX_W-1:0]   slot;
      logic signed [15:0] rect_x;
      logic signed [15:0] rect_y;
      logic [11:0]        rect_w;
      logic [11:0]        rect_h;
      logic [3:0]         kind;
      logic               has_listener;
      logic               map_flag;
   } cmd_type;

   // One table entry as held in the slot memory.
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [11:0]        w;
      logic [11:0]        h;
      logic [3:0]         kind;
      logic               listens;
   } entry_type;

   // A found pair waiting to be sent.
   typedef struct packed {
      logic [IDX_W-1:0] slot_a;
      logic [IDX_W-1:0] slot_b;
      logic             notify_a;
      logic             notify_b;
   } pair_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN_A,
      ST_SCAN_PAIR,
      ST_SCAN_END
   } back_state_type;

endpackage

`default_nettype wire

// File: rtl/core/aabb_pair_collision_scan.sv
`default_nettype none

// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    action, slot, rect_x/y/w/h, kind, flags
// rsp_      out        rsp_valid/stall    status, slot_a/b, notify_a/b, last
// csr_      in         csr_we             csr_index, csr_wdata (mask rows)
//
// Add, remove and the clears are handled in the back end and give one beat.
// A scan tests every pair of slots, one pair per cycle through the single read
// port of the slot memory while no stalled response holds it.
// Reset is synchronous; it empties the table and zeroes the notify mask.
// A two-entry command queue lets requests enter while the back end is busy.
// A stalled response holds the scan at the next pair that must be sent.

module aabb_pair_collision_scan (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [2:0]                      req_action,
   input  wire logic [2:0]                      req_slot,
   input  wire logic signed [15:0]              req_rect_x,
   input  wire logic signed [15:0]              req_rect_y,
   input  wire logic [11:0]                     req_rect_w,
   input  wire logic [11:0]                     req_rect_h,
   input  wire logic [3:0]                      req_kind,
   input  wire logic                            req_has_listener,
   input  wire logic                            req_map_flag,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic [2:0]                           rsp_slot_a,
   output logic [2:0]                           rsp_slot_b,
   output logic                                 rsp_notify_a,
   output logic                                 rsp_notify_b,
   output logic                                 rsp_last,
   input  wire logic                            csr_we,
   input  wire logic [apcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [apcs_pkg::MASK_W-1:0]     csr_wdata
);
   import apcs_pkg::*;

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   // Front end: accepts and classifies request beats.
   apcs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_slot         (req_slot),
      .req_rect_x       (req_rect_x),
      .req_rect_y       (req_rect_y),
      .req_rect_w       (req_rect_w),
      .req_rect_h       (req_rect_h),
      .req_kind         (req_kind),
      .req_has_listener (req_has_listener),
      .req_map_flag     (req_map_flag),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop)
   );

   // Back end: slot table, scan sequencer and response register.
   apcs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_pop      (cmd_pop),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_slot_a   (rsp_slot_a),
      .rsp_slot_b   (rsp_slot_b),
      .rsp_notify_a (rsp_notify_a),
      .rsp_notify_b (rsp_notify_b),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

// File: rtl/core/apcs_front.sv
`default_nettype none

module apcs_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_action,
   input  wire logic [2:0]         req_slot,
   input  wire logic signed [15:0] req_rect_x,
   input  wire logic signed [15:0] req_rect_y,
   input  wire logic [11:0]        req_rect_w,
   input  wire logic [11:0]        req_rect_h,
   input  wire logic [3:0]         req_kind,
   input  wire logic               req_has_listener,
   input  wire logic               req_map_flag,
   output logic                    cmd_valid,
   output apcs_pkg::cmd_type       cmd,
   input  wire logic               cmd_pop
);
   import apcs_pkg::*;

   cmd_type           q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   cmd_type           cls;
   logic              push;

   // Classify the incoming beat into an operation for the back end.
   always_comb begin
      cls.slot         = IDX_W'(req_slot);
      cls.rect_x       = req_rect_x;
      cls.rect_y       = req_rect_y;
      cls.rect_w       = req_rect_w;
      cls.rect_h       = req_rect_h;
      cls.kind         = req_kind;
      cls.has_listener = req_has_listener;
      cls.map_flag     = req_map_flag;
      unique case (req_action)
         ACT_ADD:       cls.op = OP_ADD;
         ACT_REMOVE:    cls.op = ({1'b0, req_slot} < SLOTS) ? OP_REMOVE : OP_NOP;
         ACT_CLEAR_ALL: cls.op = OP_CLEAR_ALL;
         ACT_CLEAR_MAP: cls.op = OP_CLEAR_MAP;
         ACT_SCAN:      cls.op = OP_SCAN;
         default:       cls.op = OP_NOP;
      endcase
   end

   // Queue bookkeeping.
   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push    ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, cmd_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage carries payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/apcs_back.sv
`default_nettype none

module apcs_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            cmd_valid,
   input  wire apcs_pkg::cmd_type               cmd,
   output logic                                 cmd_pop,
   input  wire logic                            csr_we,
   input  wire logic [apcs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [apcs_pkg::MASK_W-1:0]     csr_wdata,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic [2:0]                           rsp_slot_a,
   output logic [2:0]                           rsp_slot_b,
   output logic                                 rsp_notify_a,
   output logic                                 rsp_notify_b,
   output logic                                 rsp_last
);
   import apcs_pkg::*;

   // Strict overlap test with 17-bit edge sums.
   function automatic logic boxes_overlap(entry_type a, entry_type b);
      logic signed [16:0] ax, ay, bx, by, axw, ayh, bxw, byh;
      ax  = $signed({a.x[15], a.x});
      ay  = $signed({a.y[15], a.y});
      bx  = $signed({b.x[15], b.x});
      by  = $signed({b.y[15], b.y});
      axw = ax + $signed({5'b0, a.w});
      ayh = ay + $signed({5'b0, a.h});
      bxw = bx + $signed({5'b0, b.w});
      byh = by + $signed({5'b0, b.h});
      return (ax < bxw) && (axw > bx) && (ay < byh) && (ayh > by);
   endfunction

   // Kind-pair mask lookup; kinds outside the table read as zero.
   function automatic logic mask_bit(logic [MASK_BITS-1:0] m, logic [3:0] row,
                                     logic [3:0] col);
      logic [7:0] pos;
      pos = 8'(row) * 8'(KINDS) + 8'(col);
      if (({4'b0, row} < 8'(KINDS)) && ({4'b0, col} < 8'(KINDS))) begin
         return m[pos];
      end
      return 1'b0;
   endfunction

   back_state_type        state_ff, state_in;
   logic [MASK_W-1:0]     mask_low_ff, mask_mid_ff, mask_high_ff;
   logic [MASK_BITS-1:0]  mask_flat;
   logic [SLOTS-1:0]      valid_ff, valid_in;
   logic [SLOTS-1:0]      map_ff, map_in;
   entry_type             mem [SLOTS];
   entry_type             rd_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic                  mem_we;
   entry_type             wr_entry;
   logic [IDX_W-1:0]      i_ff, i_in, k_ff, k_in;
   entry_type             a_ff, a_in, next_a_ff, next_a_in;
   logic                  pend_valid_ff, pend_valid_in;
   pair_type              pend_ff, pend_in;
   pair_type              found;
   logic                  free_found;
   logic [IDX_W-1:0]      free_idx;
   logic                  out_free, hit, advance, last_k, last_row;
   logic                  out_load;
   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [2:0]            rsp_slot_a_ff, rsp_slot_a_in;
   logic [2:0]            rsp_slot_b_ff, rsp_slot_b_in;
   logic                  rsp_notify_a_ff, rsp_notify_a_in;
   logic                  rsp_notify_b_ff, rsp_notify_b_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Mask registers, written by index.
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_low_ff  <= '0;
         mask_mid_ff  <= '0;
         mask_high_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MASK_LOW:  mask_low_ff  <= csr_wdata;
            CSR_MASK_MID:  mask_mid_ff  <= csr_wdata;
            CSR_MASK_HIGH: mask_high_ff <= csr_wdata;
            default:       ;
         endcase
      end
   end

   assign mask_flat = {mask_high_ff, mask_mid_ff, mask_low_ff};

   // Lowest free slot for an add.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (!valid_ff[s]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(s);
         end
      end
   end

   // Pair test between the held row entry and the entry just read.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign hit      = valid_ff[i_ff] && valid_ff[k_ff] && boxes_overlap(a_ff, rd_ff);
   assign last_k   = (k_ff == IDX_W'(SLOTS - 1));
   assign last_row = (i_ff == IDX_W'(SLOTS - 2));
   assign advance  = !(hit && pend_valid_ff && !out_free);

   always_comb begin
      found.slot_a   = i_ff;
      found.slot_b   = k_ff;
      found.notify_a = mask_bit(mask_flat, a_ff.kind, rd_ff.kind) && a_ff.listens;
      found.notify_b = mask_bit(mask_flat, rd_ff.kind, a_ff.kind) && rd_ff.listens;
   end

   always_comb begin
      wr_entry.x       = cmd.rect_x;
      wr_entry.y       = cmd.rect_y;
      wr_entry.w       = cmd.rect_w;
      wr_entry.h       = cmd.rect_h;
      wr_entry.kind    = cmd.kind;
      wr_entry.listens = cmd.has_listener;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && (cmd.op == OP_SCAN)) begin
               state_in = ST_SCAN_A;
            end
         end
         ST_SCAN_A: state_in = ST_SCAN_PAIR;
         ST_SCAN_PAIR: begin
            if (advance && last_k && last_row) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and result selection for each state.
   always_comb begin
      cmd_pop         = 1'b0;
      mem_we          = 1'b0;
      rd_addr         = '0;
      valid_in        = valid_ff;
      map_in          = map_ff;
      i_in            = i_ff;
      k_in            = k_ff;
      a_in            = a_ff;
      next_a_in       = next_a_ff;
      pend_valid_in   = pend_valid_ff;
      pend_in         = pend_ff;
      out_load        = 1'b0;
      rsp_status_in   = STATUS_DONE;
      rsp_slot_a_in   = '0;
      rsp_slot_b_in   = '0;
      rsp_notify_a_in = 1'b0;
      rsp_notify_b_in = 1'b0;
      rsp_last_in     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && (cmd.op == OP_SCAN)) begin
               cmd_pop       = 1'b1;
               pend_valid_in = 1'b0;
            end else if (cmd_valid && out_free) begin
               cmd_pop     = 1'b1;
               out_load    = 1'b1;
               rsp_last_in = 1'b1;
               case (cmd.op)
                  OP_ADD: begin
                     if (free_found) begin
                        mem_we             = 1'b1;
                        valid_in[free_idx] = 1'b1;
                        map_in[free_idx]   = cmd.map_flag;
                        rsp_slot_a_in      = 3'(free_idx);
                     end else begin
                        rsp_status_in = STATUS_FULL;
                     end
                  end
                  OP_REMOVE:    valid_in[cmd.slot] = 1'b0;
                  OP_CLEAR_ALL: valid_in = '0;
                  OP_CLEAR_MAP: valid_in = valid_ff & ~map_ff;
                  default:      ;
               endcase
            end
         end
         ST_SCAN_A: begin
            a_in    = rd_ff;
            i_in    = '0;
            k_in    = IDX_W'(1);
            rd_addr = IDX_W'(1);
         end
         ST_SCAN_PAIR: begin
            // The entry next to the row head becomes the next row head.
            if (k_ff == i_ff + IDX_W'(1)) begin
               next_a_in = rd_ff;
            end
            if (advance) begin
               if (hit) begin
                  pend_valid_in = 1'b1;
                  pend_in       = found;
                  if (pend_valid_ff) begin
                     out_load        = 1'b1;
                     rsp_status_in   = STATUS_PAIR;
                     rsp_slot_a_in   = 3'(pend_ff.slot_a);
                     rsp_slot_b_in   = 3'(pend_ff.slot_b);
                     rsp_notify_a_in = pend_ff.notify_a;
                     rsp_notify_b_in = pend_ff.notify_b;
                  end
               end
               if (last_k) begin
                  if (!last_row) begin
                     i_in    = i_ff + IDX_W'(1);
                     k_in    = i_ff + IDX_W'(2);
                     a_in    = next_a_ff;
                     rd_addr = i_ff + IDX_W'(2);
                  end
               end else begin
                  k_in    = k_ff + IDX_W'(1);
                  rd_addr = k_ff + IDX_W'(1);
               end
            end else begin
               rd_addr = k_ff;
            end
         end
         ST_SCAN_END: begin
            if (out_free) begin
               out_load      = 1'b1;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               if (pend_valid_ff) begin
                  rsp_status_in   = STATUS_PAIR;
                  rsp_slot_a_in   = 3'(pend_ff.slot_a);
                  rsp_slot_b_in   = 3'(pend_ff.slot_b);
                  rsp_notify_a_in = pend_ff.notify_a;
                  rsp_notify_b_in = pend_ff.notify_b;
               end else begin
                  rsp_status_in = STATUS_NONE;
               end
            end
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      map_ff    <= map_in;
      i_ff      <= i_in;
      k_ff      <= k_in;
      a_ff      <= a_in;
      next_a_ff <= next_a_in;
      pend_ff   <= pend_in;
      if (out_load) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_slot_a_ff   <= rsp_slot_a_in;
         rsp_slot_b_ff   <= rsp_slot_b_in;
         rsp_notify_a_ff <= rsp_notify_a_in;
         rsp_notify_b_ff <= rsp_notify_b_in;
         rsp_last_ff     <= rsp_last_in;
      end
   end

   // Slot memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[free_idx] <= wr_entry;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_slot_a   = rsp_slot_a_ff;
   assign rsp_slot_b   = rsp_slot_b_ff;
   assign rsp_notify_a = rsp_notify_a_ff;
   assign rsp_notify_b = rsp_notify_b_ff;
   assign rsp_last     = rsp_last_ff;

   // A command leaves the queue only when the back end is idle.
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == ST_IDLE) && cmd_valid)
      else $error("command taken outside idle");

   // The output register is never loaded over a held beat.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten");

   // No pair may be left pending once a scan has finished.
   a_pend_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending pair left after scan");

   // The scan only ever visits pairs with the higher slot second.
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_PAIR) |-> (k_ff > i_ff))
      else $error("scan pair out of order");

endmodule

`default_nettype wire

// File: bench/tb_aabb_pair_collision_scan.sv
`timescale 1ns / 1ps

module tb_aabb_pair_collision_scan;
   import apcs_pkg::*;

   // Action codes that the block does not know and must answer with a plain done beat.
   localparam logic [2:0] ACT_SPARE_5 = 3'd5;
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;

   localparam int          PHASE_ITEMS     = 39;
   localparam int          HOLD_OFF_CYCLES = 400;
   localparam int          QUIET_LIMIT     = 2000;
   localparam int          TAIL_CYCLES     = 64;
   localparam logic [47:0] ALL_ONES        = 48'hFFFF_FFFF_FFFF;

   typedef struct {
      logic [2:0]         action;
      logic [2:0]         slot;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [11:0]        w;
      logic [11:0]        h;
      logic [3:0]         kind;
      logic               listens;
      logic               map;
   } request_type;

   typedef struct {
      logic [1:0] status;
      logic [2:0] slot_a;
      logic [2:0] slot_b;
      logic       notify_a;
      logic       notify_b;
      logic       last;
   } outcome_type;

   // A directed row; typed rows carry the single beat that they must produce.
   typedef struct {
      request_type req;
      bit          typed;
      logic [1:0]  status;
      logic [2:0]  slot_a;
   } plan_row_type;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_stall;
   logic [2:0]           req_action       = ACT_SCAN;
   logic [2:0]           req_slot         = 3'd0;
   logic signed [15:0]   req_rect_x       = 16'sd0;
   logic signed [15:0]   req_rect_y       = 16'sd0;
   logic [11:0]          req_rect_w       = 12'd0;
   logic [11:0]          req_rect_h       = 12'd0;
   logic [3:0]           req_kind         = 4'd0;
   logic                 req_has_listener = 1'b0;
   logic                 req_map_flag     = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall        = 1'b0;
   logic [1:0]           rsp_status;
   logic [2:0]           rsp_slot_a;
   logic [2:0]           rsp_slot_b;
   logic                 rsp_notify_a;
   logic                 rsp_notify_b;
   logic                 rsp_last;
   logic                 csr_we           = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = CSR_MASK_LOW;
   logic [MASK_W-1:0]    csr_wdata        = '0;

   // Shadow copy of the collider table and the notify mask.
   bit                   tbl_valid [SLOTS];
   int                   tbl_x [SLOTS];
   int                   tbl_y [SLOTS];
   int                   tbl_w [SLOTS];
   int                   tbl_h [SLOTS];
   logic [3:0]           tbl_kind [SLOTS];
   bit                   tbl_listens [SLOTS];
   bit                   tbl_map [SLOTS];
   logic [MASK_W-1:0]    mask_rows [3];

   // Beats owed by the block, oldest first.
   outcome_type          owed [$];
   outcome_type          want;

   int                   errors          = 0;
   int                   n_requests      = 0;
   int                   n_scans         = 0;
   int                   n_pairs         = 0;
   int                   n_full          = 0;
   int                   n_beats         = 0;
   int                   n_held          = 0;
   int                   busiest_scan    = 0;
   int                   quiet_cycles    = 0;
   bit                   squeeze_request = 1'b0;

   aabb_pair_collision_scan i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_slot         (req_slot),
      .req_rect_x       (req_rect_x),
      .req_rect_y       (req_rect_y),
      .req_rect_w       (req_rect_w),
      .req_rect_h       (req_rect_h),
      .req_kind         (req_kind),
      .req_has_listener (req_has_listener),
      .req_map_flag     (req_map_flag),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_slot_a       (rsp_slot_a),
      .rsp_slot_b       (rsp_slot_b),
      .rsp_notify_a     (rsp_notify_a),
      .rsp_notify_b     (rsp_notify_b),
      .rsp_last         (rsp_last),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #1 clock = ~clock;

   // Notify bit for a kind pair; kinds above eleven never hit the mask.
   function automatic logic kind_pair_hit(input logic [3:0] row, input logic [3:0] col);
      int r;
      int c;
      r = row;
      c = col;
      if (r >= KINDS || c >= KINDS) return 1'b0;
      return mask_rows[r / 4][(r % 4) * 12 + c];
   endfunction

   // Strict overlap of two stored boxes; the sums are formed in full integers.
   function automatic bit boxes_overlap(input int a, input int b);
      return tbl_x[a] < tbl_x[b] + tbl_w[b] && tbl_x[a] + tbl_w[a] > tbl_x[b] &&
             tbl_y[a] < tbl_y[b] + tbl_h[b] && tbl_y[a] + tbl_h[a] > tbl_y[b];
   endfunction

   // Applies one accepted request to the shadow table and queues the beats it owes.
   task automatic play_request(input request_type r);
      int found;
      int pairs;
      found = -1;
      pairs = 0;
      case (r.action) inside
         ACT_ADD: begin
            for (int i = 0; i < SLOTS; i++)
               if (!tbl_valid[i] && found < 0) found = i;
            if (found < 0) begin
               owed.push_back('{STATUS_FULL, 3'd0, 3'd0, 1'b0, 1'b0, 1'b1});
            end else begin
               tbl_valid[found]   = 1'b1;
               tbl_x[found]       = r.x;
               tbl_y[found]       = r.y;
               tbl_w[found]       = r.w;
               tbl_h[found]       = r.h;
               tbl_kind[found]    = r.kind;
               tbl_listens[found] = r.listens;
               tbl_map[found]     = r.map;
               owed.push_back('{STATUS_DONE, 3'(found), 3'd0, 1'b0, 1'b0, 1'b1});
            end
         end
         ACT_REMOVE: begin
            if (int'(r.slot) < SLOTS) tbl_valid[r.slot] = 1'b0;
            owed.push_back('{STATUS_DONE, 3'd0, 3'd0, 1'b0, 1'b0, 1'b1});
         end
         ACT_CLEAR_ALL, ACT_CLEAR_MAP: begin
            for (int i = 0; i < SLOTS; i++)
               if (r.action == ACT_CLEAR_ALL || tbl_map[i]) tbl_valid[i] = 1'b0;
            owed.push_back('{STATUS_DONE, 3'd0, 3'd0, 1'b0, 1'b0, 1'b1});
         end
         ACT_SCAN: begin
            n_scans++;
            for (int i = 0; i < SLOTS; i++) begin
               for (int k = i + 1; k < SLOTS; k++) begin
                  if (tbl_valid[i] && tbl_valid[k] && boxes_overlap(i, k)) begin
                     owed.push_back('{STATUS_PAIR, 3'(i), 3'(k),
                                      kind_pair_hit(tbl_kind[i], tbl_kind[k]) & tbl_listens[i],
                                      kind_pair_hit(tbl_kind[k], tbl_kind[i]) & tbl_listens[k],
                                      1'b0});
                     pairs++;
                  end
               end
            end
            if (pairs == 0) owed.push_back('{STATUS_NONE, 3'd0, 3'd0, 1'b0, 1'b0, 1'b1});
            else owed[owed.size() - 1].last = 1'b1;
            n_pairs += pairs;
            if (pairs > busiest_scan) busiest_scan = pairs;
         end
         default: begin
            owed.push_back('{STATUS_DONE, 3'd0, 3'd0, 1'b0, 1'b0, 1'b1});
         end
      endcase
   endtask

   // Presents one request, holds it until the block takes the beat, then predicts it.
   task automatic offer(input request_type r);
      req_valid        <= 1'b1;
      req_action       <= r.action;
      req_slot         <= r.slot;
      req_rect_x       <= r.x;
      req_rect_y       <= r.y;
      req_rect_w       <= r.w;
      req_rect_h       <= r.h;
      req_kind         <= r.kind;
      req_has_listener <= r.listens;
      req_map_flag     <= r.map;
      do @(posedge clock); while (req_stall !== 1'b0);
      n_requests++;
      play_request(r);
   endtask

   // Writes the three mask registers one after another; the block is idle here.
   task automatic load_mask(input logic [MASK_W-1:0] rows_low, input logic [MASK_W-1:0] rows_mid,
                            input logic [MASK_W-1:0] rows_high);
      logic [MASK_W-1:0] value [3];
      value[0] = rows_low;
      value[1] = rows_mid;
      value[2] = rows_high;
      for (int i = 0; i < 3; i++) begin
         csr_we       <= 1'b1;
         csr_index    <= (i == 0) ? CSR_MASK_LOW : (i == 1) ? CSR_MASK_MID : CSR_MASK_HIGH;
         csr_wdata    <= value[i];
         mask_rows[i]  = value[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic drain;
      while (owed.size() != 0) @(posedge clock);
   endtask

   function automatic plan_row_type plan_row(input logic [2:0] action, input logic [2:0] slot,
                                             input int x, input int y, input int w, input int h,
                                             input int kind, input bit listens, input bit map,
                                             input bit typed, input logic [1:0] status,
                                             input logic [2:0] slot_a);
      plan_row_type p;
      p.req    = '{action, slot, 16'(x), 16'(y), 12'(w), 12'(h), 4'(kind), listens, map};
      p.typed  = typed;
      p.status = status;
      p.slot_a = slot_a;
      return p;
   endfunction

   // Random request: mostly adds and scans on a crowded patch, so pairs are common.
   function automatic request_type random_request();
      request_type r;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 44)      r.action = ACT_ADD;
      else if (pick < 58) r.action = ACT_REMOVE;
      else if (pick < 62) r.action = ACT_CLEAR_MAP;
      else if (pick < 65) r.action = ACT_CLEAR_ALL;
      else if (pick < 95) r.action = ACT_SCAN;
      else                r.action = ACT_SPARE_5 + 3'($urandom_range(0, 2));
      r.slot = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 4) == 0) begin
         r.x = 16'($urandom);
         r.y = 16'($urandom);
         r.w = 12'($urandom);
         r.h = 12'($urandom);
      end else begin
         r.x = 16'(int'($urandom_range(0, 400)) - 200);
         r.y = 16'(int'($urandom_range(0, 400)) - 200);
         r.w = 12'($urandom_range(0, 160));
         r.h = 12'($urandom_range(0, 160));
      end
      r.kind    = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(12, 15))
                                              : 4'($urandom_range(0, 11));
      r.listens = 1'($urandom);
      r.map     = 1'($urandom);
      return r;
   endfunction

   // Sends a run of random requests in bursts, mostly with gaps between the bursts.
   task automatic send_batch(input int count);
      int burst_left;
      int gap;
      burst_left = 0;
      for (int n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0 && n > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         offer(random_request());
         burst_left--;
      end
      req_valid <= 1'b0;
   endtask

   task automatic check_field(input string what, input logic [2:0] expected,
                              input logic [2:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s expected %0d, got %0d", $time, what, expected, actual);
         errors++;
      end
   endtask

   // Response side: every accepted beat is matched against the oldest owed beat.
   always @(posedge clock) begin
      if (!reset && req_valid && req_stall) n_held++;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         n_beats++;
         if (rsp_status == STATUS_FULL) n_full++;
         if (owed.size() == 0) begin
            $display("%0t: beat with nothing owed, expected none, got status %0d slots %0d/%0d",
                     $time, rsp_status, rsp_slot_a, rsp_slot_b);
            errors++;
         end else begin
            want = owed.pop_front();
            check_field("status", 3'(want.status), 3'(rsp_status));
            check_field("slot_a", want.slot_a, rsp_slot_a);
            check_field("slot_b", want.slot_b, rsp_slot_b);
            check_field("notify_a", 3'(want.notify_a), 3'(rsp_notify_a));
            check_field("notify_b", 3'(want.notify_b), 3'(rsp_notify_b));
            check_field("last", 3'(want.last), 3'(rsp_last));
         end
      end
   end

   // Receiver stall pattern: modes of random length, plus one long hold-off on request.
   initial begin
      stall_mode_type mode;
      int             mode_left;
      int             hold_left;
      mode      = STALL_NONE;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (squeeze_request) begin
            squeeze_request = 1'b0;
            hold_left       = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode      = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            case (mode)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
               default:     rsp_stall <= (mode_left % 3 == 0);
            endcase
         end
      end
   end

   // Watchdog: too long without any beat moving on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d beats still owed",
                     $time, quiet_cycles, owed.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Main sequence: reset, directed rows, then random phases under several masks.
   initial begin
      plan_row_type plan [$];
      plan_row_type p;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      load_mask(ALL_ONES, ALL_ONES, ALL_ONES);

      // Coordinate extremes, a full table, spare actions, kinds above eleven,
      // zero-size and edge-touching boxes, and scans of an empty table.
      plan.push_back(plan_row(ACT_SCAN, 0, 0, 0, 0, 0, 0, 0, 0, 1, STATUS_NONE, 0));
      plan.push_back(plan_row(ACT_ADD, 0, -32768, -32768, 4095, 4095, 0, 1, 1, 1, STATUS_DONE, 0));
      plan.push_back(plan_row(ACT_ADD, 0, -30000, -30000, 10, 10, 11, 1, 0, 1, STATUS_DONE, 1));
      plan.push_back(plan_row(ACT_ADD, 0, 32767, 32767, 4095, 4095, 5, 0, 1, 1, STATUS_DONE, 2));
      plan.push_back(plan_row(ACT_ADD, 0, 32760, 32760, 100, 100, 12, 1, 0, 1, STATUS_DONE, 3));
      plan.push_back(plan_row(ACT_ADD, 0, -30000, -30000, 0, 0, 3, 1, 0, 1, STATUS_DONE, 4));
      plan.push_back(plan_row(ACT_ADD, 0, 0, 0, 4095, 1, 15, 1, 1, 1, STATUS_DONE, 5));
      plan.push_back(plan_row(ACT_ADD, 0, 10, 0, 1, 4095, 7, 1, 0, 1, STATUS_DONE, 6));
      plan.push_back(plan_row(ACT_ADD, 0, -32768, 32767, 1, 1, 9, 0, 0, 1, STATUS_DONE, 7));
      plan.push_back(plan_row(ACT_ADD, 0, 5, 5, 5, 5, 1, 1, 1, 1, STATUS_FULL, 0));
      plan.push_back(plan_row(ACT_SCAN, 7, -1, -1, 4095, 4095, 15, 1, 1, 0, STATUS_DONE, 0));
      plan.push_back(plan_row(ACT_REMOVE, 4, 0, 0, 0, 0, 0, 0, 0, 1, STATUS_DONE, 0));
      plan.push_back(plan_row(ACT_REMOVE, 4, 0, 0, 0, 0, 0, 0, 0, 1, STATUS_DONE, 0));
      plan.push_back(plan_row(ACT_SPARE_5, 3, 100, 100, 10, 10, 2, 1, 1, 1, STATUS_DONE, 0));
      plan.push_back(plan_row(ACT_SPARE_6, 5, -1, -1, 4095, 4095, 15, 1, 1, 1, STATUS_DONE, 0));
      plan.push_back(plan_row(ACT_SPARE_7, 7, 0, 0, 0, 0, 0, 0, 0, 1, STATUS_DONE, 0));
      plan.push_back(plan_row(ACT_ADD, 0, 4000, -4, 2048, 2048, 10, 1, 0, 1, STATUS_DONE, 4));
      plan.push_back(plan_row(ACT_SCAN, 0, 0, 0, 0, 0, 0, 0, 0, 0, STATUS_DONE, 0));
      plan.push_back(plan_row(ACT_CLEAR_MAP, 0, 0, 0, 0, 0, 0, 0, 0, 1, STATUS_DONE, 0));
      plan.push_back(plan_row(ACT_SCAN, 0, 0, 0, 0, 0, 0, 0, 0, 0, STATUS_DONE, 0));
      plan.push_back(plan_row(ACT_CLEAR_ALL, 0, 0, 0, 0, 0, 0, 0, 0, 1, STATUS_DONE, 0));
      plan.push_back(plan_row(ACT_SCAN, 0, 0, 0, 0, 0, 0, 0, 0, 1, STATUS_NONE, 0));
      plan.push_back(plan_row(ACT_ADD, 0, 0, 0, 10, 10, 4, 1, 0, 1, STATUS_DONE, 0));
      plan.push_back(plan_row(ACT_ADD, 0, 10, 0, 10, 10, 4, 1, 0, 1, STATUS_DONE, 1));
      plan.push_back(plan_row(ACT_SCAN, 0, 0, 0, 0, 0, 0, 0, 0, 1, STATUS_NONE, 0));

      foreach (plan[i]) begin
         p = plan[i];
         if (i > 0 && $urandom_range(0, 2) == 0) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         offer(p.req);
         // A typed row is held to the beat written in its row, not to the shadow.
         if (p.typed) begin
            void'(owed.pop_back());
            owed.push_back('{p.status, p.slot_a, 3'd0, 1'b0, 1'b0, 1'b1});
         end
      end
      req_valid <= 1'b0;
      drain();

      // Random phases; the third one starts with the long receiver hold-off.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: load_mask(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                         48'({$urandom, $urandom}));
            1: load_mask('0, '0, '0);
            2: load_mask(ALL_ONES, ALL_ONES, ALL_ONES);
            default: load_mask(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555,
                               48'({$urandom, $urandom}));
         endcase
         if (phase == 2) squeeze_request = 1'b1;
         send_batch(PHASE_ITEMS);
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Run covered %0d requests, %0d of them scans, under five mask settings.",
               n_requests, n_scans);
      $display("%0d beats checked, %0d pairs (at most %0d in a scan), %0d full, %0d held.",
               n_beats, n_pairs, busiest_scan, n_full, n_held);
      if (errors == 0 && owed.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/apcs_pkg.sv
rtl/core/apcs_front.sv
rtl/core/apcs_back.sv
rtl/core/aabb_pair_collision_scan.sv
bench/tb_aabb_pair_collision_scan.sv
